// ===== hw/rtl/rtch_pkg.sv =====
// ----------------------------------------------------------------------------
// rtch_pkg
// Shared constants, command/status types and the MAC program for the
// closest-hit ray/triangle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rtch_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IDX_BITS  = 16;
    localparam int COORD_W   = 32;
    localparam int DIR_W     = 18;
    localparam int EPS_W     = 16;
    localparam int DIST_W    = 31;
    localparam int DIFF_W    = COORD_W + 1;          // edges and origin offsets
    localparam int H_W       = 52;                   // dir x e2
    localparam int Q_W       = 68;                   // s x e1
    localparam int DET_W     = 88;                   // det, u, v numerators
    localparam int A_W       = 68;                   // wide MAC operand
    localparam int B_W       = 36;                   // narrow MAC operand, whole digits
    localparam int DIG_W     = 4;
    localparam int DIGITS    = B_W / DIG_W;
    localparam int ACC_W     = 104;                  // also holds the t numerator
    localparam int PROG_LEN  = 24;
    localparam int PC_W      = 5;
    localparam int CNT_W     = 5;
    localparam int SAT_SH    = DIST_W - FRAC_BITS;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 3'd6;

    // wide operand sources
    localparam logic [3:0] A_E2X = 4'd0;
    localparam logic [3:0] A_E2Y = 4'd1;
    localparam logic [3:0] A_E2Z = 4'd2;
    localparam logic [3:0] A_H0  = 4'd3;
    localparam logic [3:0] A_H1  = 4'd4;
    localparam logic [3:0] A_H2  = 4'd5;
    localparam logic [3:0] A_SX  = 4'd6;
    localparam logic [3:0] A_SY  = 4'd7;
    localparam logic [3:0] A_SZ  = 4'd8;
    localparam logic [3:0] A_Q0  = 4'd9;
    localparam logic [3:0] A_Q1  = 4'd10;
    localparam logic [3:0] A_Q2  = 4'd11;

    // narrow operand sources
    localparam logic [3:0] B_DX  = 4'd0;
    localparam logic [3:0] B_DY  = 4'd1;
    localparam logic [3:0] B_DZ  = 4'd2;
    localparam logic [3:0] B_E1X = 4'd3;
    localparam logic [3:0] B_E1Y = 4'd4;
    localparam logic [3:0] B_E1Z = 4'd5;
    localparam logic [3:0] B_SX  = 4'd6;
    localparam logic [3:0] B_SY  = 4'd7;
    localparam logic [3:0] B_SZ  = 4'd8;
    localparam logic [3:0] B_E2X = 4'd9;
    localparam logic [3:0] B_E2Y = 4'd10;
    localparam logic [3:0] B_E2Z = 4'd11;

    // result destinations
    localparam logic [3:0] DST_H0  = 4'd0;
    localparam logic [3:0] DST_H1  = 4'd1;
    localparam logic [3:0] DST_H2  = 4'd2;
    localparam logic [3:0] DST_DET = 4'd3;
    localparam logic [3:0] DST_UN  = 4'd4;
    localparam logic [3:0] DST_Q0  = 4'd5;
    localparam logic [3:0] DST_Q1  = 4'd6;
    localparam logic [3:0] DST_Q2  = 4'd7;
    localparam logic [3:0] DST_VN  = 4'd8;
    localparam logic [3:0] DST_TN  = 4'd9;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] dst;
    } mac_op_t;

    typedef struct packed {
        logic            capture;
        logic            mac_load;
        logic            mac_step;
        logic            mac_last_step;
        logic [PC_W-1:0] pc;
        logic            norm;
        logic            test;
        logic            div_init;
        logic            div_step;
        logic            update;
        logic            coord;
        logic            emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit_go;
        logic is_last;
        logic out_busy;
    } dp_status_t;

    function automatic mac_op_t mk_op(input logic [3:0] a, input logic [3:0] b,
                                      input logic n, input logic f, input logic l,
                                      input logic [3:0] d);
        mac_op_t r;
        r.a_sel = a;
        r.b_sel = b;
        r.neg   = n;
        r.first = f;
        r.last  = l;
        r.dst   = d;
        return r;
    endfunction

    // h = dir x e2, det = e1.h, u = s.h, q = s x e1, v = dir.q, t = e2.q
    function automatic mac_op_t mac_prog(input logic [PC_W-1:0] pc);
        mac_op_t r;
        case (pc)
            5'd0:    r = mk_op(A_E2Z, B_DY,  1'b0, 1'b1, 1'b0, DST_H0);
            5'd1:    r = mk_op(A_E2Y, B_DZ,  1'b1, 1'b0, 1'b1, DST_H0);
            5'd2:    r = mk_op(A_E2X, B_DZ,  1'b0, 1'b1, 1'b0, DST_H1);
            5'd3:    r = mk_op(A_E2Z, B_DX,  1'b1, 1'b0, 1'b1, DST_H1);
            5'd4:    r = mk_op(A_E2Y, B_DX,  1'b0, 1'b1, 1'b0, DST_H2);
            5'd5:    r = mk_op(A_E2X, B_DY,  1'b1, 1'b0, 1'b1, DST_H2);
            5'd6:    r = mk_op(A_H0,  B_E1X, 1'b0, 1'b1, 1'b0, DST_DET);
            5'd7:    r = mk_op(A_H1,  B_E1Y, 1'b0, 1'b0, 1'b0, DST_DET);
            5'd8:    r = mk_op(A_H2,  B_E1Z, 1'b0, 1'b0, 1'b1, DST_DET);
            5'd9:    r = mk_op(A_H0,  B_SX,  1'b0, 1'b1, 1'b0, DST_UN);
            5'd10:   r = mk_op(A_H1,  B_SY,  1'b0, 1'b0, 1'b0, DST_UN);
            5'd11:   r = mk_op(A_H2,  B_SZ,  1'b0, 1'b0, 1'b1, DST_UN);
            5'd12:   r = mk_op(A_SY,  B_E1Z, 1'b0, 1'b1, 1'b0, DST_Q0);
            5'd13:   r = mk_op(A_SZ,  B_E1Y, 1'b1, 1'b0, 1'b1, DST_Q0);
            5'd14:   r = mk_op(A_SZ,  B_E1X, 1'b0, 1'b1, 1'b0, DST_Q1);
            5'd15:   r = mk_op(A_SX,  B_E1Z, 1'b1, 1'b0, 1'b1, DST_Q1);
            5'd16:   r = mk_op(A_SX,  B_E1Y, 1'b0, 1'b1, 1'b0, DST_Q2);
            5'd17:   r = mk_op(A_SY,  B_E1X, 1'b1, 1'b0, 1'b1, DST_Q2);
            5'd18:   r = mk_op(A_Q0,  B_DX,  1'b0, 1'b1, 1'b0, DST_VN);
            5'd19:   r = mk_op(A_Q1,  B_DY,  1'b0, 1'b0, 1'b0, DST_VN);
            5'd20:   r = mk_op(A_Q2,  B_DZ,  1'b0, 1'b0, 1'b1, DST_VN);
            5'd21:   r = mk_op(A_Q0,  B_E2X, 1'b0, 1'b1, 1'b0, DST_TN);
            5'd22:   r = mk_op(A_Q1,  B_E2Y, 1'b0, 1'b0, 1'b0, DST_TN);
            5'd23:   r = mk_op(A_Q2,  B_E2Z, 1'b0, 1'b0, 1'b1, DST_TN);
            default: r = mk_op(A_E2X, B_DX,  1'b0, 1'b0, 1'b0, DST_H0);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtch_if.sv =====
// ----------------------------------------------------------------------------
// rtch_if
// Channel interfaces: triangle input, hit result output, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtch_tri_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] vertex0_x;
    logic signed [31:0] vertex0_y;
    logic signed [31:0] vertex0_z;
    logic signed [31:0] vertex1_x;
    logic signed [31:0] vertex1_y;
    logic signed [31:0] vertex1_z;
    logic signed [31:0] vertex2_x;
    logic signed [31:0] vertex2_y;
    logic signed [31:0] vertex2_z;
    logic        is_last;

    modport source (output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
                    vertex1_z, vertex2_x, vertex2_y, vertex2_z, is_last, input ready);
    modport sink   (input valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
                    vertex1_z, vertex2_x, vertex2_y, vertex2_z, is_last, output ready);
endinterface

interface rtch_hit_if;
    logic        valid;
    logic        ready;
    logic        any_hit;
    logic [30:0] best_distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic [15:0] best_triangle;

    modport source (output valid, any_hit, best_distance, hit_x, hit_y, hit_z,
                    best_triangle, input ready);
    modport sink   (input valid, any_hit, best_distance, hit_x, hit_y, hit_z,
                    best_triangle, output ready);
endinterface

interface rtch_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rtch_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtch_ctrl
// Sequencer: steps the shared MAC program, the divider and the emit phase.
// ----------------------------------------------------------------------------
`default_nettype none

module rtch_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rtch_pkg::dp_status_t status,
    output rtch_pkg::ctrl_cmd_t       cmd
);

    localparam int PC_W  = rtch_pkg::PC_W;
    localparam int CNT_W = rtch_pkg::CNT_W;
    localparam logic [PC_W-1:0]  PC_END  = PC_W'(rtch_pkg::PROG_LEN - 1);
    localparam logic [CNT_W-1:0] DIG_END = CNT_W'(rtch_pkg::DIGITS - 1);
    localparam logic [CNT_W-1:0] DIV_END = CNT_W'(rtch_pkg::DIST_W - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_LOAD  = 10'b00_0000_0010,
        S_STEP  = 10'b00_0000_0100,
        S_NORM  = 10'b00_0000_1000,
        S_TEST  = 10'b00_0001_0000,
        S_DIV   = 10'b00_0010_0000,
        S_UPD   = 10'b00_0100_0000,
        S_COORD = 10'b00_1000_0000,
        S_EMIT  = 10'b01_0000_0000,
        S_DINIT = 10'b10_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.pc     = pc_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    pc_next     = '0;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.mac_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_STEP;
            end
            S_STEP:
            begin
                cmd.mac_step = 1'b1;
                if (cnt_reg == DIG_END)
                begin
                    cmd.mac_last_step = 1'b1;
                    if (pc_reg == PC_END)
                        state_next = S_NORM;
                    else
                    begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_NORM:
            begin
                cmd.norm   = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                cmd.test   = 1'b1;
                state_next = status.hit_go ? S_DINIT : S_UPD;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_END)
                    state_next = S_UPD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = status.is_last ? S_COORD : S_IDLE;
            end
            S_COORD:
            begin
                cmd.coord  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rtch_datapath.sv =====
// ----------------------------------------------------------------------------
// rtch_datapath
// Ray registers, shared 4-bit-digit multiply-accumulate unit, restoring
// divider for t, closest-hit tracking and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtch_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rtch_pkg::ctrl_cmd_t cmd,
    output rtch_pkg::dp_status_t     status,
    input  wire logic                in_ready,
    rtch_cfg_if.sink                 cfg,
    rtch_tri_if.sink                 triangle,
    rtch_hit_if.source               result
);

    localparam int F     = rtch_pkg::FRAC_BITS;
    localparam int CW    = rtch_pkg::COORD_W;
    localparam int DRW   = rtch_pkg::DIR_W;
    localparam int DFW   = rtch_pkg::DIFF_W;
    localparam int HW    = rtch_pkg::H_W;
    localparam int QW    = rtch_pkg::Q_W;
    localparam int DW    = rtch_pkg::DET_W;
    localparam int AW    = rtch_pkg::A_W;
    localparam int BW    = rtch_pkg::B_W;
    localparam int GW    = rtch_pkg::DIG_W;
    localparam int ACW   = rtch_pkg::ACC_W;
    localparam int TW    = rtch_pkg::DIST_W;
    localparam int IW    = rtch_pkg::IDX_BITS;
    localparam int SH    = rtch_pkg::SAT_SH;
    localparam int PW    = CW + 3;
    localparam int PRW   = DRW + TW + 1;
    localparam logic [TW-1:0] DIST_MAX = '1;
    localparam logic signed [PW-1:0] PMAX = PW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] PMIN = -PMAX - PW'(1);

    // ray registers
    logic signed [CW-1:0]  org_reg [3];
    logic signed [DRW-1:0] dir_reg [3];
    logic [rtch_pkg::EPS_W-1:0] eps_reg;

    // per-triangle working registers
    logic signed [DFW-1:0] e1_reg [3];
    logic signed [DFW-1:0] e2_reg [3];
    logic signed [DFW-1:0] s_reg  [3];
    logic signed [HW-1:0]  h_reg  [3];
    logic signed [QW-1:0]  q_reg  [3];
    logic signed [DW-1:0]  det_reg, un_reg, vn_reg;
    logic signed [ACW-1:0] tn_reg;
    logic                  last_reg;

    // MAC
    rtch_pkg::mac_op_t     op;
    logic signed [AW-1:0]  a_val;
    logic signed [BW-1:0]  b_val;
    logic signed [ACW-1:0] a_sh_reg, acc_reg, acc_next;
    logic signed [BW-1:0]  b_sh_reg;
    logic signed [GW:0]    digit;

    // test and divide
    logic                  hit_ok_c, sat_c, hit_ok_reg, sat_reg;
    logic signed [DW:0]    uv_sum;
    logic [DW-1:0]         eps_w;
    logic signed [ACW-1:0] det_w;
    logic [DW-1:0]         rem_reg;
    logic [TW-1:0]         nlo_reg, quot_reg;
    logic [DW:0]           rem_sh, rem_diff;
    logic [TW-1:0]         t_val;

    // closest hit
    logic                  found_reg;
    logic [TW-1:0]         closest_reg;
    logic [IW-1:0]         count_reg, closest_tri_reg;

    // emit
    logic signed [PRW-1:0] prod_reg [3];
    logic signed [PW-1:0]  p_sum [3];
    logic signed [CW-1:0]  p_sat [3];
    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [TW-1:0]         out_dist_reg;
    logic signed [CW-1:0]  out_x_reg, out_y_reg, out_z_reg;
    logic [IW-1:0]         out_tri_reg;

    assign cfg.ready      = 1'b1;
    assign triangle.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= DRW'(1 << F);
            eps_reg    <= rtch_pkg::EPS_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rtch_pkg::CFG_ORG_X: org_reg[0] <= cfg.data;
                rtch_pkg::CFG_ORG_Y: org_reg[1] <= cfg.data;
                rtch_pkg::CFG_ORG_Z: org_reg[2] <= cfg.data;
                rtch_pkg::CFG_DIR_X: dir_reg[0] <= cfg.data[DRW-1:0];
                rtch_pkg::CFG_DIR_Y: dir_reg[1] <= cfg.data[DRW-1:0];
                rtch_pkg::CFG_DIR_Z: dir_reg[2] <= cfg.data[DRW-1:0];
                rtch_pkg::CFG_EPS:   eps_reg    <= cfg.data[rtch_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // operand selection for the shared MAC
    assign op = rtch_pkg::mac_prog(cmd.pc);

    always_comb
    begin
        case (op.a_sel)
            rtch_pkg::A_E2X: a_val = AW'(e2_reg[0]);
            rtch_pkg::A_E2Y: a_val = AW'(e2_reg[1]);
            rtch_pkg::A_E2Z: a_val = AW'(e2_reg[2]);
            rtch_pkg::A_H0:  a_val = AW'(h_reg[0]);
            rtch_pkg::A_H1:  a_val = AW'(h_reg[1]);
            rtch_pkg::A_H2:  a_val = AW'(h_reg[2]);
            rtch_pkg::A_SX:  a_val = AW'(s_reg[0]);
            rtch_pkg::A_SY:  a_val = AW'(s_reg[1]);
            rtch_pkg::A_SZ:  a_val = AW'(s_reg[2]);
            rtch_pkg::A_Q0:  a_val = AW'(q_reg[0]);
            rtch_pkg::A_Q1:  a_val = AW'(q_reg[1]);
            rtch_pkg::A_Q2:  a_val = AW'(q_reg[2]);
            default:         a_val = '0;
        endcase
        case (op.b_sel)
            rtch_pkg::B_DX:  b_val = BW'(dir_reg[0]);
            rtch_pkg::B_DY:  b_val = BW'(dir_reg[1]);
            rtch_pkg::B_DZ:  b_val = BW'(dir_reg[2]);
            rtch_pkg::B_E1X: b_val = BW'(e1_reg[0]);
            rtch_pkg::B_E1Y: b_val = BW'(e1_reg[1]);
            rtch_pkg::B_E1Z: b_val = BW'(e1_reg[2]);
            rtch_pkg::B_SX:  b_val = BW'(s_reg[0]);
            rtch_pkg::B_SY:  b_val = BW'(s_reg[1]);
            rtch_pkg::B_SZ:  b_val = BW'(s_reg[2]);
            rtch_pkg::B_E2X: b_val = BW'(e2_reg[0]);
            rtch_pkg::B_E2Y: b_val = BW'(e2_reg[1]);
            rtch_pkg::B_E2Z: b_val = BW'(e2_reg[2]);
            default:         b_val = '0;
        endcase
    end

    // LSB-first digits; the top digit carries the sign
    assign digit    = cmd.mac_last_step ? {b_sh_reg[GW-1], b_sh_reg[GW-1:0]}
                                        : {1'b0, b_sh_reg[GW-1:0]};
    assign acc_next = acc_reg + a_sh_reg * digit;

    // tests on the sign-normalised numerators
    assign eps_w    = DW'(eps_reg) << (2 * F);
    assign uv_sum   = (DW+1)'(un_reg) + (DW+1)'(vn_reg);
    assign det_w    = ACW'(det_reg) <<< SH;
    assign hit_ok_c = (det_reg != '0) && !(det_reg < $signed(eps_w))
                   && !un_reg[DW-1] && !(det_reg < un_reg)
                   && !vn_reg[DW-1] && !((DW+1)'(det_reg) < uv_sum)
                   && !tn_reg[ACW-1] && (tn_reg != '0);
    assign sat_c    = tn_reg >= det_w;

    assign rem_sh   = {rem_reg, nlo_reg[TW-1]};
    assign rem_diff = rem_sh - {1'b0, $unsigned(det_reg)};
    assign t_val    = sat_reg ? DIST_MAX : quot_reg;

    assign status.hit_go   = hit_ok_c && !sat_c;
    assign status.is_last  = last_reg;
    assign status.out_busy = out_valid_reg && !result.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            e1_reg[0] <= DFW'(triangle.vertex1_x) - DFW'(triangle.vertex0_x);
            e1_reg[1] <= DFW'(triangle.vertex1_y) - DFW'(triangle.vertex0_y);
            e1_reg[2] <= DFW'(triangle.vertex1_z) - DFW'(triangle.vertex0_z);
            e2_reg[0] <= DFW'(triangle.vertex2_x) - DFW'(triangle.vertex0_x);
            e2_reg[1] <= DFW'(triangle.vertex2_y) - DFW'(triangle.vertex0_y);
            e2_reg[2] <= DFW'(triangle.vertex2_z) - DFW'(triangle.vertex0_z);
            s_reg[0]  <= DFW'(org_reg[0]) - DFW'(triangle.vertex0_x);
            s_reg[1]  <= DFW'(org_reg[1]) - DFW'(triangle.vertex0_y);
            s_reg[2]  <= DFW'(org_reg[2]) - DFW'(triangle.vertex0_z);
            last_reg  <= triangle.is_last;
        end
        if (cmd.mac_load)
        begin
            a_sh_reg <= op.neg ? -ACW'(a_val) : ACW'(a_val);
            b_sh_reg <= b_val;
            if (op.first)
                acc_reg <= '0;
        end
        if (cmd.mac_step)
        begin
            acc_reg  <= acc_next;
            a_sh_reg <= a_sh_reg <<< GW;
            b_sh_reg <= b_sh_reg >>> GW;
            if (cmd.mac_last_step && op.last)
            begin
                case (op.dst)
                    rtch_pkg::DST_H0:  h_reg[0] <= acc_next[HW-1:0];
                    rtch_pkg::DST_H1:  h_reg[1] <= acc_next[HW-1:0];
                    rtch_pkg::DST_H2:  h_reg[2] <= acc_next[HW-1:0];
                    rtch_pkg::DST_DET: det_reg  <= acc_next[DW-1:0];
                    rtch_pkg::DST_UN:  un_reg   <= acc_next[DW-1:0];
                    rtch_pkg::DST_Q0:  q_reg[0] <= acc_next[QW-1:0];
                    rtch_pkg::DST_Q1:  q_reg[1] <= acc_next[QW-1:0];
                    rtch_pkg::DST_Q2:  q_reg[2] <= acc_next[QW-1:0];
                    rtch_pkg::DST_VN:  vn_reg   <= acc_next[DW-1:0];
                    rtch_pkg::DST_TN:  tn_reg   <= acc_next;
                    default: ;
                endcase
            end
        end
        if (cmd.norm && det_reg[DW-1])
        begin
            det_reg <= -det_reg;
            un_reg  <= -un_reg;
            vn_reg  <= -vn_reg;
            tn_reg  <= -tn_reg;
        end
        if (cmd.test)
        begin
            hit_ok_reg <= hit_ok_c;
            sat_reg    <= sat_c;
        end
        // t = (tn << F) / det; tn < det << SH here, so TW quotient bits suffice
        if (cmd.div_init)
        begin
            rem_reg  <= tn_reg[SH+DW-1:SH];
            nlo_reg  <= {tn_reg[SH-1:0], F'(0)};
            quot_reg <= '0;
        end
        if (cmd.div_step)
        begin
            nlo_reg <= nlo_reg << 1;
            if (!rem_diff[DW])
            begin
                rem_reg  <= rem_diff[DW-1:0];
                quot_reg <= {quot_reg[TW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[DW-1:0];
                quot_reg <= {quot_reg[TW-2:0], 1'b0};
            end
        end
        if (cmd.coord)
        begin
            prod_reg[0] <= dir_reg[0] * $signed({1'b0, closest_reg});
            prod_reg[1] <= dir_reg[1] * $signed({1'b0, closest_reg});
            prod_reg[2] <= dir_reg[2] * $signed({1'b0, closest_reg});
        end
        if (cmd.emit)
        begin
            out_hit_reg  <= found_reg;
            out_dist_reg <= found_reg ? closest_reg : '0;
            out_x_reg    <= found_reg ? p_sat[0] : '0;
            out_y_reg    <= found_reg ? p_sat[1] : '0;
            out_z_reg    <= found_reg ? p_sat[2] : '0;
            out_tri_reg  <= found_reg ? closest_tri_reg : '0;
        end
    end

    // hit point: origin + floor(dir * t / 2^F), saturated
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_sum[i] = PW'(org_reg[i]) + PW'(prod_reg[i] >>> F);
            if (p_sum[i] > PMAX)
                p_sat[i] = PMAX[CW-1:0];
            else if (p_sum[i] < PMIN)
                p_sat[i] = PMIN[CW-1:0];
            else
                p_sat[i] = p_sum[i][CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg       <= 1'b0;
            closest_reg     <= DIST_MAX;
            count_reg       <= '0;
            closest_tri_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                count_reg <= count_reg + 1'b1;
                // ties keep the earlier triangle
                if (hit_ok_reg && (t_val != '0) && (!found_reg || t_val < closest_reg))
                begin
                    found_reg       <= 1'b1;
                    closest_reg     <= t_val;
                    closest_tri_reg <= count_reg;
                end
            end
            if (cmd.emit)
            begin
                found_reg       <= 1'b0;
                closest_reg     <= DIST_MAX;
                count_reg       <= '0;
                closest_tri_reg <= '0;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.any_hit       = out_hit_reg;
    assign result.best_distance = out_dist_reg;
    assign result.hit_x         = out_x_reg;
    assign result.hit_y         = out_y_reg;
    assign result.hit_z         = out_z_reg;
    assign result.best_triangle = out_tri_reg;

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> closest_reg != '0)
        else $error("stored hit distance is zero");

    a_nohit_max: assert property (@(posedge clk) disable iff (!rst_n)
        !found_reg |-> closest_reg == DIST_MAX)
        else $error("closest distance not at maximum without a hit");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> rem_reg < $unsigned(det_reg))
        else $error("divider remainder not below divisor");

    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !found_reg && count_reg == '0 && out_valid_reg)
        else $error("ray state not cleared after result");

endmodule

`default_nettype wire

// ===== hw/rtl/ray_triangle_closest_hit_unit.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_unit
// Moller-Trumbore closest-hit search of one ray over a stream of triangles.
// ----------------------------------------------------------------------------
// Channel    Dir  Transaction
// cfg        in   register write: index (0..6), data
// triangle   in   three vertices and is_last
// result     out  any_hit, best_distance, hit_x/y/z, best_triangle
//
// The 24 products of each triangle run through one shared multiply-accumulate
// unit at 4 bits a cycle; t comes from a 31-step restoring divider, which only
// triangles that pass the tests reach. The last triangle of a ray also goes
// through the hit-point and emit steps. Reset needs no clearing pass. A stalled
// result holds its register; the next triangle is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_closest_hit_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rtch_cfg_if.sink   cfg,
    rtch_tri_if.sink   triangle,
    rtch_hit_if.source result
);

    rtch_pkg::ctrl_cmd_t  cmd;
    rtch_pkg::dp_status_t status;
    logic                 in_ready;

    rtch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (triangle.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rtch_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_ready (in_ready),
        .cfg      (cfg),
        .triangle (triangle),
        .result   (result)
    );

endmodule

`default_nettype wire

// ===== test/tb_ray_triangle_closest_hit_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_closest_hit_unit
// Streams rays of triangles through the closest-hit unit and checks every
// result against an exact integer model of the intersection test, under
// random stalls on both channels and a range of ray settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ray_triangle_closest_hit_unit;

    localparam logic [rtch_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;   // no register behind it
    localparam int ONE       = 1 << rtch_pkg::FRAC_BITS;
    localparam int SETTLE    = 300;                       // longest triangle plus margin

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] vtx [9];
        logic               last;
    } tri_t;

    typedef struct {
        logic               any_hit;
        logic [30:0]        span_t;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        idx;
    } hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rtch_cfg_if cfg_ch ();
    rtch_tri_if tri_ch ();
    rtch_hit_if res_ch ();

    ray_triangle_closest_hit_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .triangle (tri_ch.sink),
        .result (res_ch.source)
    );

    always #1 clk = ~clk;

    // ray registers and per-ray search state of the model
    logic signed [31:0] org [3];
    logic signed [17:0] dir [3];
    logic [15:0]        eps;
    logic [31:0]        closest_dist;
    logic               ray_hit;
    logic [15:0]        tri_count;
    logic [15:0]        closest_tri;

    hit_t pending_hits [$];
    int   errors    = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    int   hold_cycles = 0;

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        tri_ch.valid = 1'b0;
        tri_ch.is_last = 1'b0;
        {tri_ch.vertex0_x, tri_ch.vertex0_y, tri_ch.vertex0_z} = '0;
        {tri_ch.vertex1_x, tri_ch.vertex1_y, tri_ch.vertex1_z} = '0;
        {tri_ch.vertex2_x, tri_ch.vertex2_y, tri_ch.vertex2_z} = '0;
        res_ch.ready = 1'b0;
    end

    function automatic void clear_search();
        closest_dist = 32'h7FFF_FFFF;
        ray_hit      = 1'b0;
        tri_count    = '0;
        closest_tri  = '0;
    endfunction

    function automatic logic signed [31:0] hit_coord(input int a);
        longint p;
        p = longint'(org[a])
            + ((longint'(dir[a]) * longint'(closest_dist)) >>> rtch_pkg::FRAC_BITS);
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        return p[31:0];
    endfunction

    // Moller-Trumbore in exact integers; returns 1 when the triangle closes a ray
    function automatic logic trace_triangle(input tri_t t, output hit_t r);
        longint v [9];
        longint d [3];
        longint e1 [3];
        longint e2 [3];
        longint s [3];
        longint h [3];
        wide_t  q [3];
        wide_t  det, un, vn, tn, thr, quo;
        logic [31:0] t_fix;
        logic   hit;
        for (int i = 0; i < 9; i++)
            v[i] = longint'(t.vtx[i]);
        for (int i = 0; i < 3; i++)
        begin
            d[i]  = longint'(dir[i]);
            e1[i] = v[3+i] - v[i];
            e2[i] = v[6+i] - v[i];
            s[i]  = longint'(org[i]) - v[i];
        end
        h[0] = d[1] * e2[2] - d[2] * e2[1];
        h[1] = d[2] * e2[0] - d[0] * e2[2];
        h[2] = d[0] * e2[1] - d[1] * e2[0];
        det = '0;
        un  = '0;
        for (int i = 0; i < 3; i++)
        begin
            det += wide_t'(e1[i]) * wide_t'(h[i]);
            un  += wide_t'(s[i]) * wide_t'(h[i]);
        end
        q[0] = wide_t'(s[1]) * wide_t'(e1[2]) - wide_t'(s[2]) * wide_t'(e1[1]);
        q[1] = wide_t'(s[2]) * wide_t'(e1[0]) - wide_t'(s[0]) * wide_t'(e1[2]);
        q[2] = wide_t'(s[0]) * wide_t'(e1[1]) - wide_t'(s[1]) * wide_t'(e1[0]);
        vn = '0;
        tn = '0;
        for (int i = 0; i < 3; i++)
        begin
            vn += wide_t'(d[i]) * q[i];
            tn += wide_t'(e2[i]) * q[i];
        end
        if (det < 0)
        begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        thr = wide_t'(longint'(eps)) <<< (2 * rtch_pkg::FRAC_BITS);
        hit = !(det == 0 || det < thr || un < 0 || det < un || vn < 0 || det < un + vn
                || tn <= 0);
        if (hit)
        begin
            quo   = (tn <<< rtch_pkg::FRAC_BITS) / det;
            t_fix = (quo > 128'sh7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
            if (t_fix != 0 && (!ray_hit || t_fix < closest_dist))
            begin
                closest_dist = t_fix;
                closest_tri  = tri_count;
                ray_hit      = 1'b1;
            end
        end
        tri_count++;
        r = '{default: '0};
        if (!t.last)
            return 1'b0;
        if (ray_hit)
        begin
            r.any_hit = 1'b1;
            r.span_t  = closest_dist[30:0];
            r.px      = hit_coord(0);
            r.py      = hit_coord(1);
            r.pz      = hit_coord(2);
            r.idx     = closest_tri;
        end
        clear_search();
        return 1'b1;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        if (res_ch.valid && res_ch.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected result transaction", $time);
                errors++;
            end
            else
            begin
                hit_t e;
                e = pending_hits.pop_front();
                if (res_ch.any_hit !== e.any_hit)
                begin
                    $display("%0t: any_hit exp %0d got %0d", $time, e.any_hit, res_ch.any_hit);
                    errors++;
                end
                if (res_ch.best_distance !== e.span_t)
                begin
                    $display("%0t: best_distance exp %h got %h", $time, e.span_t,
                             res_ch.best_distance);
                    errors++;
                end
                if (res_ch.hit_x !== e.px)
                begin
                    $display("%0t: hit_x exp %h got %h", $time, e.px, res_ch.hit_x);
                    errors++;
                end
                if (res_ch.hit_y !== e.py)
                begin
                    $display("%0t: hit_y exp %h got %h", $time, e.py, res_ch.hit_y);
                    errors++;
                end
                if (res_ch.hit_z !== e.pz)
                begin
                    $display("%0t: hit_z exp %h got %h", $time, e.pz, res_ch.hit_z);
                    errors++;
                end
                if (res_ch.best_triangle !== e.idx)
                begin
                    $display("%0t: best_triangle exp %0d got %0d", $time, e.idx,
                             res_ch.best_triangle);
                    errors++;
                end
            end
        end
    end

    // result receiver: random stalls, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_cycles--;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // ---------------- drivers ----------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            rtch_pkg::CFG_ORG_X: org[0] = data;
            rtch_pkg::CFG_ORG_Y: org[1] = data;
            rtch_pkg::CFG_ORG_Z: org[2] = data;
            rtch_pkg::CFG_DIR_X: dir[0] = data[17:0];
            rtch_pkg::CFG_DIR_Y: dir[1] = data[17:0];
            rtch_pkg::CFG_DIR_Z: dir[2] = data[17:0];
            rtch_pkg::CFG_EPS:   eps    = data[15:0];
            default: ;
        endcase
    endtask

    task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, ep);
        write_reg(rtch_pkg::CFG_ORG_X, ox);
        write_reg(rtch_pkg::CFG_ORG_Y, oy);
        write_reg(rtch_pkg::CFG_ORG_Z, oz);
        write_reg(rtch_pkg::CFG_DIR_X, dx);
        write_reg(rtch_pkg::CFG_DIR_Y, dy);
        write_reg(rtch_pkg::CFG_DIR_Z, dz);
        write_reg(rtch_pkg::CFG_EPS, ep);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_triangle(input tri_t t);
        hit_t r;
        if ($urandom_range(99) < send_idle)
        begin
            tri_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        tri_ch.valid     <= 1'b1;
        tri_ch.vertex0_x <= t.vtx[0];
        tri_ch.vertex0_y <= t.vtx[1];
        tri_ch.vertex0_z <= t.vtx[2];
        tri_ch.vertex1_x <= t.vtx[3];
        tri_ch.vertex1_y <= t.vtx[4];
        tri_ch.vertex1_z <= t.vtx[5];
        tri_ch.vertex2_x <= t.vtx[6];
        tri_ch.vertex2_y <= t.vtx[7];
        tri_ch.vertex2_z <= t.vtx[8];
        tri_ch.is_last   <= t.last;
        do @(posedge clk); while (!tri_ch.ready);
        if (trace_triangle(t, r))
            pending_hits = {pending_hits, r};
    endtask

    task automatic stop_sending();
        tri_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic tri_t mk_tri(input int x0, y0, z0, x1, y1, z1, x2, y2, z2,
                                    input logic last);
        tri_t t;
        t.vtx = '{x0, y0, z0, x1, y1, z1, x2, y2, z2};
        t.last = last;
        return t;
    endfunction

    function automatic int jitter(input int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // triangle placed around a point on the ray so that many of them are hit
    function automatic tri_t aimed_tri(input logic last);
        tri_t t;
        int   reach;
        int   span;
        reach = $urandom_range(40 * ONE, ONE / 4);
        span = ($urandom_range(3) == 0) ? ONE / 8 : 4 * ONE;
        for (int a = 0; a < 3; a++)
        begin
            longint p;
            p = longint'(org[a]) + ((longint'(dir[a]) * reach) >>> rtch_pkg::FRAC_BITS);
            for (int k = 0; k < 3; k++)
                t.vtx[3*k+a] = p[31:0] + jitter(span);
        end
        t.last = last;
        return t;
    endfunction

    function automatic tri_t noise_tri(input logic last);
        tri_t t;
        for (int i = 0; i < 9; i++)
            t.vtx[i] = $urandom;
        t.last = last;
        return t;
    endfunction

    task automatic random_ray_setting();
        logic [31:0] o [3];
        logic [31:0] d [3];
        logic [31:0] ep;
        for (int a = 0; a < 3; a++)
        begin
            o[a] = ($urandom_range(7) == 0) ? $urandom : jitter(16 * ONE);
            case ($urandom_range(9))
                0:       d[a] = $urandom;              // raw bit pattern, not limited to unit length
                1:       d[a] = ($urandom_range(1)) ? ONE : -ONE;
                2:       d[a] = 0;
                default: d[a] = jitter(ONE);
            endcase
        end
        case ($urandom_range(7))
            0:       ep = 16'hFFFF;
            1:       ep = $urandom;
            2:       ep = 0;
            default: ep = $urandom_range(3);
        endcase
        if ($urandom_range(3) == 0)
        begin
            write_reg(CFG_SPARE, $urandom);
            cfg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        set_ray(o[0], o[1], o[2], d[0], d[1], d[2], ep);
    endtask

    task automatic random_rays(input int items);
        int sent;
        sent = 0;
        while (sent < items)
        begin
            int len;
            if ($urandom_range(4) == 0)
            begin
                stop_sending();
                drain();
                random_ray_setting();
            end
            len = $urandom_range(8, 1);
            for (int k = 0; k < len; k++)
            begin
                logic last;
                last = (k == len - 1) || ($urandom_range(19) == 0);
                if ($urandom_range(4) == 0)
                    send_triangle(noise_tri(last));
                else
                    send_triangle(aimed_tri(last));
            end
            sent += len;
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        send_idle = 0;
        recv_idle = 0;
        // default ray points along +z from the origin
        send_triangle(mk_tri(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, 1'b1));
        // behind, far, near, tie with near, miss: near one must win
        send_triangle(mk_tri(-ONE, -ONE, -3*ONE, ONE, -ONE, -3*ONE, 0, ONE, -3*ONE, 1'b0));
        send_triangle(mk_tri(-ONE, -ONE, 9*ONE, ONE, -ONE, 9*ONE, 0, ONE, 9*ONE, 1'b0));
        send_triangle(mk_tri(-ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE, 0, ONE, 2*ONE, 1'b0));
        send_triangle(mk_tri(-ONE, -ONE, 2*ONE, ONE, -ONE, 2*ONE, 0, ONE, 2*ONE, 1'b0));
        send_triangle(mk_tri(9*ONE, -ONE, 2*ONE, 11*ONE, -ONE, 2*ONE, 10*ONE, ONE, 2*ONE,
                             1'b1));
        // a ray that hits nothing
        send_triangle(mk_tri(5*ONE, 5*ONE, ONE, 6*ONE, 5*ONE, ONE, 5*ONE, 6*ONE, ONE, 1'b1));
        // hit right on an edge and a vertex
        send_triangle(mk_tri(0, 0, 3*ONE, ONE, 0, 3*ONE, 0, ONE, 3*ONE, 1'b1));
        // extreme vertex values
        send_triangle(mk_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 1'b0));
        send_triangle(mk_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 32'h8000_0000, 1'b1));
        stop_sending();
        drain();
        // zero epsilon: a triangle containing the ray direction is still rejected
        set_ray(0, 0, 0, 0, 0, ONE, 0);
        send_triangle(mk_tri(0, -ONE, ONE, 0, ONE, ONE, 0, 0, 4*ONE, 1'b0));
        send_triangle(mk_tri(-ONE, -ONE, 7*ONE, ONE, -ONE, 7*ONE, 0, ONE, 7*ONE, 1'b1));
        stop_sending();
        drain();
        // largest epsilon drops a small triangle; tiny direction saturates distance
        set_ray(-3*ONE, 32'h7FFF_0000, 32'h8000_0000, 32'h1FFFF, 32'h20000, 1, 16'hFFFF);
        send_triangle(mk_tri(-ONE/64, 32'h7FFF_0000, 32'h8000_0100, ONE/64,
                             32'h7FFF_0000, 32'h8000_0100, 0, 32'h7FFF_0400,
                             32'h8000_0100, 1'b1));
        stop_sending();
        drain();
        set_ray(32'h7FFF_0000, 0, 0, ONE, 0, 1, 0);
        send_triangle(mk_tri(32'h7FFF_0000 - ONE, -ONE, ONE, 32'h7FFF_0000 + ONE/2, -ONE,
                             ONE, 32'h7FFF_0000, ONE, ONE, 1'b1));
        send_triangle(mk_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE, 1'b1));
        stop_sending();
        drain();
    endtask

    task automatic test_stalls(input int s_idle, input int r_idle, input int items);
        send_idle = s_idle;
        recv_idle = r_idle;
        random_rays(items);
        stop_sending();
        drain();
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        set_ray(0, 0, 0, 0, 0, ONE, 1);
        hold_cycles = 6000;
        for (int k = 0; k < 12; k++)
            send_triangle(aimed_tri(k % 3 == 2));
        // pause until the unit has handed everything over, then carry on
        stop_sending();
        while (pending_hits.size() != 0)
            @(posedge clk);
        for (int k = 0; k < 6; k++)
            send_triangle(aimed_tri(k % 2 == 1));
        stop_sending();
        drain();
    endtask

    initial
    begin
        org = '{0, 0, 0};
        dir = '{0, 0, 18'(ONE)};
        eps = 16'd1;
        clear_search();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_stalls(23, 76, 500);
        test_stalls(76, 23, 500);
        test_stalls(0, 0, 500);
        test_backpressure();
        if (errors == 0 && pending_hits.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== ray_triangle_closest_hit_unit.f =====
hw/rtl/rtch_pkg.sv
hw/rtl/rtch_if.sv
hw/rtl/rtch_ctrl.sv
hw/rtl/rtch_datapath.sv
hw/rtl/ray_triangle_closest_hit_unit.sv
test/tb_ray_triangle_closest_hit_unit.sv
